FILE: hdl/png_chunk_stream_checker_macros.svh
// Assertion macros shared by the checker of png_chunk_stream_checker.
// Depends on nothing; included by the checker file.
`ifndef PNG_CHUNK_STREAM_CHECKER_MACROS_SVH
`define PNG_CHUNK_STREAM_CHECKER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PCSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcsc assertion failed");

// Check a property on every rising edge, reset included.
`define PCSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pcsc assertion failed");

`endif

FILE: hdl/pcsc_pkg.sv
// Shared types, codes and helper functions of the PNG chunk stream checker.
// Depends on nothing; imported by every module of the block.
package pcsc_pkg;

    localparam int LENGTH_BITS_DEFAULT = 31;

    // Input queue between front and back; depth must stay a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int SIG_LEN = 8;
    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [31:0] TYPE_TEXT  = 32'h7445_5874;
    localparam logic [31:0] TYPE_ZTEXT = 32'h7A54_5874;
    localparam logic [31:0] TYPE_TIME  = 32'h7449_4D45;

    localparam int TIME_BYTES = 7;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [1:0] OUTCOME_ACCEPT = 2'd0;
    localparam logic [1:0] OUTCOME_END    = 2'd1;
    localparam logic [1:0] OUTCOME_REJECT = 2'd2;

    localparam logic [2:0] ERR_BAD_SIGNATURE = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED     = 3'd1;
    localparam logic [2:0] ERR_LENGTH        = 3'd2;
    localparam logic [2:0] ERR_CRC           = 3'd3;
    localparam logic [2:0] ERR_TIME_LENGTH   = 3'd4;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_ZTEXT = 2'd1;
    localparam logic [1:0] KIND_TIME  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // One classified file byte as it sits in the queue.
    typedef struct packed {
        logic [7:0]         data;
        logic               eof;
        logic [SIG_LEN-1:0] sig_hit;
    } t_item;

    // Head of the queue as the back end sees it.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [1:0] kind_of(input logic [31:0] t);
        logic [1:0] k;
        if (t == TYPE_TEXT) begin
            k = KIND_TEXT;
        end else if (t == TYPE_ZTEXT) begin
            k = KIND_ZTEXT;
        end else if (t == TYPE_TIME) begin
            k = KIND_TIME;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

FILE: hdl/pcsc_front.sv
// Front end of the PNG chunk stream checker: accepts bytes, tags them with
// signature matches and holds them in a short queue. Depends on pcsc_pkg.
module pcsc_front import pcsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    input  logic        i_pop,
    output t_queue_head o_head
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   push;
    t_item                  item_in;

    assign o_in_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;

    // Classify: compare the byte against every signature position at once.
    always_comb begin
        item_in.data = i_data_byte;
        item_in.eof  = i_end_of_file;
        for (int k = 0; k < SIG_LEN; k++) begin
            item_in.sig_hit[k] = (i_data_byte == SIG_BYTES[k]);
        end
    end

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

FILE: hdl/pcsc_back.sv
// Back end of the PNG chunk stream checker: chunk framing, CRC-32, tIME
// capture and the registered result. Depends on pcsc_pkg.
module pcsc_back import pcsc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_outcome,
    output logic [2:0]  o_error_code,
    output logic [1:0]  o_chunk_kind,
    output logic [30:0] o_chunk_length,
    output logic        o_has_time,
    output logic [15:0] o_year,
    output logic [7:0]  o_month,
    output logic [7:0]  o_day,
    output logic [7:0]  o_hour,
    output logic [7:0]  o_minute,
    output logic [7:0]  o_second
);

    typedef enum logic [4:0] {
        PH_SIG  = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CRC  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [2:0]  error_code;
        logic [1:0]  chunk_kind;
        logic [30:0] chunk_length;
        logic        has_time;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } t_result;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0] r_dcnt, n_dcnt;
    logic [LENGTH_BITS-1:0] dcnt_inc;
    logic [31:0]            r_len, n_len;
    logic [23:0]            r_type, n_type;
    logic [1:0]             r_kind, n_kind;
    logic [31:0]            r_crc, n_crc;
    logic [31:0]            r_exp, n_exp;
    logic                   r_rej, n_rej;
    logic [7:0]             r_time [TIME_BYTES];
    logic                   r_out_valid, n_out_valid;
    t_result                r_res, n_res;

    logic        pop;
    logic [7:0]  b;
    logic        eof;
    logic [31:0] crc_upd, len_shift, exp_shift, type_word;
    logic        rej, accept_chunk, go_next, go_restart, time_we;
    logic [2:0]  rej_code;

    assign pop       = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop     = pop;
    assign b         = i_head.item.data;
    assign eof       = i_head.item.eof;
    assign crc_upd   = crc_byte(r_crc, b);
    assign len_shift = {r_len[23:0], b};
    assign exp_shift = {r_exp[23:0], b};
    assign type_word = {r_type, b};
    assign dcnt_inc  = r_dcnt + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_dcnt       = r_dcnt;
        n_len        = r_len;
        n_type       = r_type;
        n_kind       = r_kind;
        n_crc        = r_crc;
        n_exp        = r_exp;
        n_rej        = r_rej;
        rej          = 1'b0;
        rej_code     = ERR_BAD_SIGNATURE;
        accept_chunk = 1'b0;
        go_next      = 1'b0;
        go_restart   = 1'b0;
        time_we      = 1'b0;
        if (pop) begin
            if (r_rej) begin
                go_restart = eof;
            end else begin
                case (r_phase)
                    PH_SIG: begin
                        if (!i_head.item.sig_hit[r_cnt]) begin
                            rej = 1'b1;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == 3'(SIG_LEN - 1)) begin
                                n_phase = PH_LEN;
                                n_cnt   = '0;
                                if (eof) begin
                                    rej      = 1'b1;
                                    rej_code = ERR_TRUNCATED;
                                end
                            end else if (eof) begin
                                rej = 1'b1;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_len = len_shift;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == 3'd3) begin
                            if ((len_shift >> LENGTH_BITS) != '0) begin
                                rej      = 1'b1;
                                rej_code = ERR_LENGTH;
                            end else begin
                                n_phase = PH_TYPE;
                                n_cnt   = '0;
                            end
                        end
                        if (eof && !rej) begin
                            rej      = 1'b1;
                            rej_code = ERR_TRUNCATED;
                        end
                    end
                    PH_TYPE: begin
                        n_type = type_word[23:0];
                        n_crc  = crc_upd;
                        n_cnt  = r_cnt + 1'b1;
                        if (r_cnt == 3'd3) begin
                            n_kind  = kind_of(type_word);
                            n_cnt   = '0;
                            n_phase = (r_len == '0) ? PH_CRC : PH_DATA;
                        end
                        if (eof) begin
                            rej      = 1'b1;
                            rej_code = ERR_TRUNCATED;
                        end
                    end
                    PH_DATA: begin
                        if (r_kind != KIND_OTHER) begin
                            n_crc = crc_upd;
                        end
                        time_we = (r_kind == KIND_TIME) &&
                                  (r_dcnt < LENGTH_BITS'(TIME_BYTES));
                        n_dcnt  = dcnt_inc;
                        if (dcnt_inc == r_len[LENGTH_BITS-1:0]) begin
                            n_phase = PH_CRC;
                            n_dcnt  = '0;
                        end
                        if (eof) begin
                            rej      = 1'b1;
                            rej_code = ERR_TRUNCATED;
                        end
                    end
                    PH_CRC: begin
                        n_exp = exp_shift;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt != 3'd3) begin
                            if (eof) begin
                                rej      = 1'b1;
                                rej_code = ERR_TRUNCATED;
                            end
                        end else if (r_kind != KIND_OTHER && exp_shift != ~r_crc) begin
                            rej      = 1'b1;
                            rej_code = ERR_CRC;
                        end else if (r_kind == KIND_TIME && r_len != 32'(TIME_BYTES)) begin
                            rej      = 1'b1;
                            rej_code = ERR_TIME_LENGTH;
                        end else begin
                            accept_chunk = 1'b1;
                            go_next      = 1'b1;
                            n_phase      = PH_LEN;
                            go_restart   = eof;
                        end
                    end
                    default: begin
                        go_restart = 1'b1;
                    end
                endcase
                if (rej) begin
                    n_rej      = 1'b1;
                    go_restart = eof;
                end
            end
            if (go_next || go_restart) begin
                n_cnt  = '0;
                n_dcnt = '0;
                n_crc  = '1;
            end
            if (go_restart) begin
                n_phase = PH_SIG;
                n_rej   = 1'b0;
            end
        end
    end

    // Result payload; time fields stay zero unless a good tIME chunk closes.
    always_comb begin
        n_res = '0;
        if (rej) begin
            n_res.outcome    = OUTCOME_REJECT;
            n_res.error_code = rej_code;
        end else begin
            n_res.outcome      = eof ? OUTCOME_END : OUTCOME_ACCEPT;
            n_res.chunk_kind   = r_kind;
            n_res.chunk_length = r_len[30:0];
            if (r_kind == KIND_TIME) begin
                n_res.has_time = 1'b1;
                n_res.year     = {r_time[0], r_time[1]};
                n_res.month    = r_time[2];
                n_res.day      = r_time[3];
                n_res.hour     = r_time[4];
                n_res.minute   = r_time[5];
                n_res.second   = r_time[6];
            end
        end
    end

    assign n_out_valid = (rej || accept_chunk) || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_crc       <= '1;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_dcnt      <= n_dcnt;
            r_crc       <= n_crc;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_type <= n_type;
        r_kind <= n_kind;
        r_exp  <= n_exp;
        if (time_we) begin
            r_time[r_dcnt[2:0]] <= b;
        end
        if (rej || accept_chunk) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_res.outcome;
    assign o_error_code   = r_res.error_code;
    assign o_chunk_kind   = r_res.chunk_kind;
    assign o_chunk_length = r_res.chunk_length;
    assign o_has_time     = r_res.has_time;
    assign o_year         = r_res.year;
    assign o_month        = r_res.month;
    assign o_day          = r_res.day;
    assign o_hour         = r_res.hour;
    assign o_minute       = r_res.minute;
    assign o_second       = r_res.second;

endmodule

FILE: hdl/png_chunk_stream_checker.sv
// PNG chunk stream checker. Feed a PNG file one byte per word with
// i_end_of_file set on the last byte. The block checks the 8-byte signature,
// then frames every chunk (big-endian length, type, data, CRC). tEXt, zTXt
// and tIME chunks are checked with CRC-32 over type and data; other types
// are skipped unchecked. Each completed chunk yields one result word:
// accepted, or valid end of file when the chunk's last CRC byte carries
// i_end_of_file. A tIME chunk must be 7 bytes long and returns its date and
// time fields. The first error yields one reject word with its error code,
// and every later byte up to and including the next end-of-file byte is
// dropped; the block then rearms for a new signature. Lengths with any bit
// at or above LENGTH_BITS set are rejected. Throughput is one byte per clock
// cycle while the result channel does not stall, limited by the byte-wide CRC
// update in the back end. A byte passes through the four-entry input queue
// and then the result register before its result word appears. No clearing
// pass follows reset.
// Depends on pcsc_pkg, pcsc_front and pcsc_back.
module png_chunk_stream_checker import pcsc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [2:0]  o_error_code,
    output logic [1:0]  o_chunk_kind,
    output logic [30:0] o_chunk_length,
    output logic        o_has_time,
    output logic [15:0] o_year,
    output logic [7:0]  o_month,
    output logic [7:0]  o_day,
    output logic [7:0]  o_hour,
    output logic [7:0]  o_minute,
    output logic [7:0]  o_second
);

    // Queue head handed from the front end; the back end pops one word per cycle
    // whenever the queue holds one and its result register is free or being drained.
    t_queue_head head;
    logic        pop;

    // Front: accept, tag signature matches, buffer.
    pcsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_pop         (pop),
        .o_head        (head)
    );

    // Back: framing, CRC, tIME capture and the result register.
    pcsc_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_outcome      (o_outcome),
        .o_error_code   (o_error_code),
        .o_chunk_kind   (o_chunk_kind),
        .o_chunk_length (o_chunk_length),
        .o_has_time     (o_has_time),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second)
    );

endmodule

FILE: hdl/pcsc_checker.sv
// Port-level assertions of the PNG chunk stream checker, bound to its top.
// Depends on pcsc_pkg and png_chunk_stream_checker_macros.svh.
`include "png_chunk_stream_checker_macros.svh"

module pcsc_checker import pcsc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_file,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_outcome,
    input logic [2:0]  o_error_code,
    input logic [1:0]  o_chunk_kind,
    input logic [30:0] o_chunk_length,
    input logic        o_has_time,
    input logic [15:0] o_year,
    input logic [7:0]  o_month,
    input logic [7:0]  o_day,
    input logic [7:0]  o_hour,
    input logic [7:0]  o_minute,
    input logic [7:0]  o_second
);

    // A reject word carries no chunk description.
    `PCSC_ASSERT(a_reject_clean, i_clk, i_rst_n, (o_out_valid && o_outcome == OUTCOME_REJECT) |-> (o_chunk_kind == KIND_TEXT && o_chunk_length == '0 && !o_has_time))

    // Time fields only come with an accepted tIME chunk of seven bytes.
    `PCSC_ASSERT(a_time_shape, i_clk, i_rst_n, (o_out_valid && o_has_time) |-> (o_chunk_kind == KIND_TIME && o_chunk_length == 31'd7 && o_outcome != OUTCOME_REJECT))

    // A stalled result word holds.
    `PCSC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_outcome) && $stable(o_error_code) && $stable(o_chunk_length)))

    // Reset empties both sides.
    `PCSC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready))

endmodule

bind png_chunk_stream_checker pcsc_checker u_pcsc_checker (.*);
